FILE: src/pprs_pkg.sv
// Package for the polyline point resampler: state and lane-op codes,
// the lane control struct and shared width constants. No dependencies.
package pprs_pkg;

  localparam int MAX_RUN_DEF    = 64;
  localparam int COORD_BITS_DEF = 32;

  // segment length (floor of a 66-bit root) and distance widths
  localparam int LEN_W = 33;
  localparam int DW    = 40;

  localparam int SPACING_RESET = 256;

  // configuration register indexes
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_SPACING     = 2'd1;
  localparam logic [1:0] REG_VERTEX_KIND = 2'd2;
  localparam logic [1:0] REG_ADD_ORDER   = 2'd3;

  // mode codes
  localparam logic [1:0] MODE_VERTEX = 2'd0;
  localparam logic [1:0] MODE_SEG    = 2'd1;
  localparam logic [1:0] MODE_LINE   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_VTX, S_SQ, S_ROOT_LD, S_ROOT, S_CHECK,
    S_M0_LD, S_M0, S_D0_LD, S_D0, S_SAVE0,
    S_MS_LD, S_MS, S_DS_LD, S_DS, S_SAVES,
    S_EMIT, S_END, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    LN_IDLE, LN_MLOAD, LN_MSTEP, LN_DLOAD, LN_DSTEP,
    LN_SAVE0, LN_SAVES, LN_STEP
  } lane_op_t;

  typedef struct packed {
    lane_op_t    op;
    logic [31:0] operand;
  } lane_ctl_t;

endpackage

FILE: src/pprs_lane.sv
// One coordinate lane: bit-serial multiply, bit-serial divide by the segment
// length, then incremental interpolation one point per step. Uses pprs_pkg.
module pprs_lane (
  input  logic                          clk,
  input  pprs_pkg::lane_ctl_t           ctl,
  input  logic signed [31:0]            a,
  input  logic signed [31:0]            b,
  input  logic [pprs_pkg::LEN_W-1:0]    len,
  output logic [31:0]                   point
);
  import pprs_pkg::*;

  logic [32:0]      mag;
  logic             neg;
  logic [64:0]      prod;
  logic [LEN_W-1:0] rem;
  logic [31:0]      q, qs;
  logic [LEN_W:0]   rs, racc;

  logic             lz;
  logic [LEN_W:0]   two_l;
  logic [33:0]      msum;
  logic [LEN_W:0]   dtr;
  logic             dge;
  logic [LEN_W+1:0] t0, t_step;
  logic signed [32:0] dif;
  logic [32:0]      absd;

  always_comb begin
    lz     = (len == '0);
    two_l  = {len, 1'b0};
    msum   = {1'b0, prod[64:32]} + {1'b0, mag};
    dtr    = {rem, prod[64]};
    dge    = (dtr >= {1'b0, len});
    t0     = {1'b0, rem, 1'b0} + (LEN_W+2)'(len);
    t_step = {1'b0, racc} + {1'b0, rs};
    dif    = {b[31], b} - {a[31], a};
    absd   = dif[32] ? 33'(-dif) : 33'(dif);
    point  = neg ? 32'(a) - q : 32'(a) + q;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      LN_MLOAD: begin
        mag  <= absd;
        neg  <= (b < a);
        prod <= {33'b0, ctl.operand};
      end
      LN_MSTEP: begin
        if (prod[0]) prod <= {msum, prod[31:1]};
        else         prod <= {1'b0, prod[64:1]};
      end
      LN_DLOAD: rem <= '0;
      LN_DSTEP: begin
        rem  <= dge ? LEN_W'(dtr - {1'b0, len}) : LEN_W'(dtr);
        prod <= {prod[63:0], dge};
      end
      LN_SAVE0: begin
        if (lz) begin
          q    <= '0;
          racc <= '0;
        end else if (t0 >= {1'b0, two_l}) begin
          q    <= prod[31:0] + 32'd1;
          racc <= (LEN_W+1)'(t0 - {1'b0, two_l});
        end else begin
          q    <= prod[31:0];
          racc <= t0[LEN_W:0];
        end
      end
      LN_SAVES: begin
        qs <= lz ? '0 : prod[31:0];
        rs <= lz ? '0 : {rem, 1'b0};
      end
      LN_STEP: begin
        if (!lz && t_step >= {1'b0, two_l}) begin
          q    <= q + qs + 32'd1;
          racc <= (LEN_W+1)'(t_step - {1'b0, two_l});
        end else begin
          q    <= q + qs;
          racc <= t_step[LEN_W:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/polyline_point_resampler.sv
// Polyline point resampler, top level. Uses pprs_pkg and pprs_lane.
// Takes vertices, emits original and inserted points.
//
// One vertex item is taken at a time; in_stall is high while it is worked on.
// Mode 0 (and code 3): one result per item, loaded when the output is free.
// A vertex that starts a line or part, or follows nothing, in modes 1 and 2
// just stores itself. A segment goes through bit-serial squaring and a
// bit-serial square root; in mode 2 it ends there if the carried offset
// exceeds its length, else two multiply/divide passes follow in four
// coordinate lanes. Load and save steps lie between acceptance and the first
// point, then one result per cycle while the output register drains. The
// serial squarer, root and lane dividers set that wait. At most MAX_RUN
// results follow one item; a cut run has truncated set on all its results.
module polyline_point_resampler #(
  parameter int MAX_RUN    = pprs_pkg::MAX_RUN_DEF,
  parameter int COORD_BITS = pprs_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // vertex channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] vz,
  input  logic signed [31:0] vm,
  input  logic               line_start,
  input  logic               part_start,
  input  logic [15:0]        tag,
  // point channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] px,
  output logic signed [31:0] py,
  output logic signed [31:0] pz,
  output logic signed [31:0] pm,
  output logic [23:0]        order_num,
  output logic               order_valid,
  output logic [15:0]        point_tag,
  output logic               last,
  output logic               truncated,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pprs_pkg::*;

  localparam int CW_EFF = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int SH     = 32 - CW_EFF;
  localparam int KW     = $clog2(MAX_RUN + 1);

  function automatic logic signed [31:0] sext(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v <<< SH;
    return t >>> SH;
  endfunction

  function automatic logic [32:0] absd(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {b[31], b} - {a[31], a};
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // config registers
  logic [1:0]  mode;
  logic [30:0] spacing;
  logic [1:0]  vertex_kind;
  logic        add_order;

  // item state
  state_t state, state_next;
  logic signed [31:0] prev_x, prev_y, prev_z, prev_m;
  logic signed [31:0] cur_x, cur_y, cur_z, cur_m;
  logic        have_prev;
  logic [23:0] order_count;
  logic [31:0] carry_offset;
  logic [15:0] cur_tag;
  logic [1:0]  md;
  logic        seg_r;

  // squarer / root
  logic [32:0] mag_x, mag_y;
  logic [65:0] sq_x, sq_y, rad;
  logic [35:0] root_rem;
  logic [LEN_W-1:0] len;
  logic [6:0]  cnt;

  // run control
  logic [31:0] off;
  logic [DW-1:0] run_pos;
  logic [KW-1:0] kc;
  logic        trunc;
  logic [32:0] mrad;
  logic [30:0] mrem;

  logic [31:0] pt_x, pt_y, pt_z, pt_m;
  lane_ctl_t   lctl;

  // comb helpers
  logic        in_acc, out_free;
  logic [1:0]  md_in;
  logic [30:0] s_eff;
  logic [33:0] sum_x, sum_y;
  logic [35:0] rem2, trial;
  logic        rge;
  logic [31:0] mt;
  logic        mge;
  logic [LEN_W-1:0] r_len;
  logic [DW-1:0] ds;
  logic        more;
  logic signed [31:0] sx, sy;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    in_acc   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
    md_in    = (mode == 2'd3) ? MODE_VERTEX : mode;
    s_eff    = (spacing == '0) ? 31'd1 : spacing;
    sx       = sext(vx);
    sy       = sext(vy);
    sum_x    = {1'b0, sq_x[65:33]} + {1'b0, mag_x};
    sum_y    = {1'b0, sq_y[65:33]} + {1'b0, mag_y};
    rem2     = {root_rem[33:0], rad[65:64]};
    trial    = 36'({len, 2'b01});
    rge      = (rem2 >= trial);
    mt       = {mrem, mrad[32]};
    mge      = (mt >= {1'b0, s_eff});
    r_len    = len - LEN_W'(off);
    ds       = run_pos + DW'(s_eff);
    if (md == MODE_SEG)
      more = (int'(kc) + 1 <= MAX_RUN - 2) &&
             ((DW'(2) * ds + DW'(s_eff)) < DW'({len, 1'b0}));
    else
      more = (int'(kc) + 1 <= MAX_RUN - 1) && (ds < DW'(len));
  end

  // next state and lane control
  always_comb begin
    state_next   = state;
    lctl.op      = LN_IDLE;
    lctl.operand = off;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (md_in == MODE_VERTEX) state_next = S_VTX;
          else if (have_prev && !line_start && !part_start) state_next = S_SQ;
          else state_next = S_DONE;
        end
      end
      S_VTX:     if (out_free) state_next = S_DONE;
      S_SQ:      if (cnt == 7'd32) state_next = S_ROOT_LD;
      S_ROOT_LD: state_next = S_ROOT;
      S_ROOT:    if (cnt == 7'd32) state_next = S_CHECK;
      S_CHECK: begin
        if (md == MODE_LINE && LEN_W'(carry_offset) > len) state_next = S_DONE;
        else state_next = S_M0_LD;
      end
      S_M0_LD: begin
        lctl.op    = LN_MLOAD;
        state_next = S_M0;
      end
      S_M0: begin
        lctl.op = LN_MSTEP;
        if (cnt == 7'd31) state_next = S_D0_LD;
      end
      S_D0_LD: begin
        lctl.op    = LN_DLOAD;
        state_next = S_D0;
      end
      S_D0: begin
        lctl.op = LN_DSTEP;
        if (cnt == 7'd64) state_next = S_SAVE0;
      end
      S_SAVE0: begin
        lctl.op    = LN_SAVE0;
        state_next = S_MS_LD;
      end
      S_MS_LD: begin
        lctl.op      = LN_MLOAD;
        lctl.operand = {1'b0, s_eff};
        state_next   = S_MS;
      end
      S_MS: begin
        lctl.op = LN_MSTEP;
        if (cnt == 7'd31) state_next = S_DS_LD;
      end
      S_DS_LD: begin
        lctl.op    = LN_DLOAD;
        state_next = S_DS;
      end
      S_DS: begin
        lctl.op = LN_DSTEP;
        if (cnt == 7'd64) state_next = S_SAVES;
      end
      S_SAVES: begin
        lctl.op    = LN_SAVES;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          lctl.op = LN_STEP;
          if (!more) state_next = (md == MODE_SEG) ? S_END : S_DONE;
        end
      end
      S_END:  if (out_free) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  pprs_lane u_lane_x (.clk, .ctl(lctl), .a(prev_x), .b(cur_x), .len, .point(pt_x));
  pprs_lane u_lane_y (.clk, .ctl(lctl), .a(prev_y), .b(cur_y), .len, .point(pt_y));
  pprs_lane u_lane_z (.clk, .ctl(lctl), .a(prev_z), .b(cur_z), .len, .point(pt_z));
  pprs_lane u_lane_m (.clk, .ctl(lctl), .a(prev_m), .b(cur_m), .len, .point(pt_m));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= MODE_VERTEX;
      spacing      <= 31'(SPACING_RESET);
      vertex_kind  <= 2'd0;
      add_order    <= 1'b0;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      prev_m       <= '0;
      have_prev    <= 1'b0;
      order_count  <= '0;
      carry_offset <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:        mode        <= cfg_data[1:0];
          REG_SPACING:     spacing     <= cfg_data[30:0];
          REG_VERTEX_KIND: vertex_kind <= cfg_data[1:0];
          REG_ADD_ORDER:   add_order   <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_x   <= sx;
            cur_y   <= sy;
            cur_z   <= sext(vz);
            cur_m   <= sext(vm);
            cur_tag <= tag;
            md      <= md_in;
            seg_r   <= have_prev && !line_start && !part_start;
            if (line_start) begin
              order_count  <= '0;
              carry_offset <= '0;
            end
            mag_x <= absd(prev_x, sx);
            mag_y <= absd(prev_y, sy);
            sq_x  <= {33'b0, absd(prev_x, sx)};
            sq_y  <= {33'b0, absd(prev_y, sy)};
            cnt   <= '0;
          end
        end
        S_SQ: begin
          sq_x <= sq_x[0] ? {sum_x, sq_x[32:1]} : {1'b0, sq_x[65:1]};
          sq_y <= sq_y[0] ? {sum_y, sq_y[32:1]} : {1'b0, sq_y[65:1]};
          cnt  <= cnt + 7'd1;
        end
        S_ROOT_LD: begin
          rad      <= sq_x + sq_y;
          root_rem <= '0;
          len      <= '0;
          cnt      <= '0;
        end
        S_ROOT: begin
          // one root bit per cycle, two radicand bits in
          root_rem <= rge ? rem2 - trial : rem2;
          len      <= {len[LEN_W-2:0], rge};
          rad      <= {rad[63:0], 2'b00};
          cnt      <= cnt + 7'd1;
        end
        S_CHECK: begin
          if (md == MODE_LINE && LEN_W'(carry_offset) > len) begin
            carry_offset <= 32'(LEN_W'(carry_offset) - len);
          end else begin
            off     <= (md == MODE_LINE) ? carry_offset : 32'd0;
            run_pos <= (md == MODE_LINE) ? DW'(carry_offset) : '0;
            kc      <= '0;
            if (md == MODE_SEG)
              trunc <= (DW'(s_eff) * DW'(2 * MAX_RUN - 1)) < DW'({len, 1'b0});
            else
              trunc <= (DW'(carry_offset) + DW'(s_eff) * DW'(MAX_RUN)) < DW'(len);
          end
          cnt <= '0;
        end
        S_M0, S_MS: cnt <= cnt + 7'd1;
        S_D0_LD: begin
          mrad <= r_len - LEN_W'(1);
          mrem <= '0;
          cnt  <= '0;
        end
        S_D0: begin
          // (r - 1) mod spacing for the carried phase
          if (cnt < 7'd33) begin
            mrem <= mge ? 31'(mt - {1'b0, s_eff}) : mt[30:0];
            mrad <= {mrad[31:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
        end
        S_DS_LD, S_M0_LD, S_MS_LD, S_SAVE0: cnt <= '0;
        S_DS: cnt <= cnt + 7'd1;
        S_SAVES: begin
          if (md == MODE_LINE)
            carry_offset <= (r_len == '0) ? {1'b0, s_eff}
                                          : 32'({1'b0, s_eff} - 32'd1 - {1'b0, mrem});
        end
        S_EMIT: begin
          if (out_free) begin
            run_pos <= ds;
            kc      <= kc + KW'(1);
          end
        end
        S_DONE: begin
          prev_x    <= cur_x;
          prev_y    <= cur_y;
          prev_z    <= cur_z;
          prev_m    <= cur_m;
          have_prev <= 1'b1;
        end
        default: ;
      endcase

      // output register load, or drop once taken
      if ((state == S_VTX || state == S_EMIT || state == S_END) && out_free) begin
        out_valid <= 1'b1;
        point_tag <= cur_tag;
        if (state == S_EMIT) begin
          px        <= pt_x;
          py        <= pt_y;
          pz        <= (vertex_kind >= 2'd1) ? pt_z : 32'sd0;
          pm        <= (vertex_kind >= 2'd2) ? pt_m : 32'sd0;
          last      <= (md == MODE_LINE) && !more;
          truncated <= trunc;
        end else begin
          px        <= cur_x;
          py        <= cur_y;
          pz        <= (vertex_kind >= 2'd1) ? cur_z : 32'sd0;
          pm        <= (vertex_kind >= 2'd2) ? cur_m : 32'sd0;
          last      <= 1'b1;
          truncated <= (state == S_END) ? trunc : 1'b0;
        end
        if (state != S_END && add_order) begin
          order_num   <= order_count;
          order_valid <= 1'b1;
          if (order_count != 24'hFFFFFF) order_count <= order_count + 24'd1;
        end else begin
          order_num   <= '0;
          order_valid <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new result shows up only from an emitting state
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_VTX || $past(state) == S_EMIT ||
                          $past(state) == S_END))
    else $error("result appeared outside an emitting state");

  // run counter stays inside the result limit
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (int'(kc) < MAX_RUN))
    else $error("run counter past limit");

  // finishing an item stores it as the previous vertex
  a_done_prev: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (have_prev && state == S_IDLE))
    else $error("item end did not store vertex");

  // a segment is only worked on with a stored previous vertex
  a_seg_prev: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (have_prev && seg_r))
    else $error("segment without previous vertex");

endmodule
